FILE: rtl/i2c_rf_pkg.sv
// Package for the two-wire register file target: item and result types,
// bus condition codes, reply kinds and fixed register constants.
// No dependencies; used by every other file in the rtl folder.
`default_nettype none

package i2c_rf_pkg;

    // Bus condition carried by one input item.
    typedef enum logic [1:0] {
        OP_STOP  = 2'd0,
        OP_START = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0] ACK_BYTE       = 8'h01;
    localparam logic [7:0] IDENTITY_INDEX = 8'h75;
    localparam logic [7:0] IDENTITY_VALUE = 8'h68;
    localparam logic [6:0] OWN_ADDR_RESET = 7'h68;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] bus_address;
        logic [7:0] write_byte;
    } item_t;

    typedef struct packed {
        logic       reply_kind;
        logic [7:0] reply_byte;
        logic [6:0] reply_address;
    } result_t;

    // One access to the register store; index is already reduced to the store depth.
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] index;
        logic [7:0] data;
    } store_req_t;

endpackage

`default_nettype wire

FILE: rtl/i2c_rf_store.sv
// Register store: a synchronous byte memory with a registered read
// and a per-entry written flag so that unwritten entries read as zero.
// Depends on i2c_rf_pkg for the access request type.
`default_nettype none

module i2c_rf_store #(
    parameter int REGISTER_COUNT = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire i2c_rf_pkg::store_req_t req,
    output logic [7:0]                  rd_data
);

    localparam int IW = $clog2(REGISTER_COUNT);

    logic [7:0]                mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] written_reg;
    logic [REGISTER_COUNT-1:0] written_next;
    logic [7:0]                rd_data_reg;
    logic                      rd_valid_reg;
    logic [IW-1:0]             index;

    assign index = req.index[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[index] <= req.data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[index];
        end
    end

    always_comb
    begin
        written_next = written_reg;
        if (req.wr_en)
        begin
            written_next[index] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            written_reg <= written_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= written_reg[index];
            end
        end
    end

    // An entry never written since reset reads as zero, whatever the memory holds.
    assign rd_data = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule

`default_nettype wire

FILE: rtl/i2c_register_file_target.sv
// Top level of the two-wire register file target: address match, pointer
// control, reply register and the register store instance.
// Depends on i2c_rf_pkg and i2c_rf_store.
//
//  Channel   Signals                  Handshake
//  -------   ----------------------   -------------------------------------------
//  item      start, busy, item        taken at a rising edge with start high, busy low
//  result    done, result             shown for one cycle with done high, no stall
//  config    cfg_we, cfg_data         own address written at an edge with cfg_we high
//
// Every item is handled in its own cycle, so busy stays low and an item may follow in
// the very next cycle. The result of an item appears with done in the cycle
// after it is taken; that latency is set by the registered read of the store.
// Reset clears the pointer, the load flag and the written flags of the store,
// so the store reads as all zero at once; no clearing pass is needed.
// The receiver cannot stall, so nothing is ever held back on the result side.
`default_nettype none

module i2c_register_file_target #(
    parameter int REGISTER_COUNT = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire i2c_rf_pkg::item_t   item,
    output logic                     done,
    output i2c_rf_pkg::result_t      result,
    input  wire logic                cfg_we,
    input  wire logic [6:0]          cfg_data
);

    localparam int IW = $clog2(REGISTER_COUNT);

    // Constant table that reduces the eight-bit pointer to a store index. It is
    // built at elaboration, so any store depth in range needs no divider.
    logic [IW-1:0] index_lut [256];

    for (genvar g = 0; g < 256; g++)
    begin : g_lut
        assign index_lut[g] = IW'(g % REGISTER_COUNT);
    end

    logic [6:0] own_address_reg;
    logic [7:0] pointer_reg;
    logic [7:0] pointer_next;
    logic       loaded_reg;
    logic       loaded_next;
    logic       done_reg;
    logic       done_next;
    logic       kind_reg;
    logic       kind_next;
    logic       ident_reg;
    logic       ident_next;
    logic [6:0] addr_reg;
    logic       take;
    logic [7:0] store_index;
    logic [7:0] rd_data;

    i2c_rf_pkg::store_req_t req;

    // Every item is handled in the cycle it is taken.
    assign busy = 1'b0;

    // Only the seven address bits are compared; the direction bit is ignored.
    assign take = start && !busy && (item.bus_address[7:1] == own_address_reg);

    assign store_index = 8'(index_lut[pointer_reg]);

    always_comb
    begin
        pointer_next = pointer_reg;
        loaded_next  = loaded_reg;
        done_next    = 1'b0;
        kind_next    = kind_reg;
        ident_next   = ident_reg;
        req          = '0;
        req.index    = store_index;
        req.data     = item.write_byte;
        if (take)
        begin
            unique case (item.opcode)
                i2c_rf_pkg::OP_STOP:
                begin
                    // A stop changes nothing and gives no reply.
                end
                i2c_rf_pkg::OP_START:
                begin
                    loaded_next = 1'b0;
                    done_next   = 1'b1;
                    kind_next   = i2c_rf_pkg::KIND_ACK;
                end
                i2c_rf_pkg::OP_WRITE:
                begin
                    if (!loaded_reg)
                    begin
                        // The first write after a start selects the register.
                        pointer_next = item.write_byte;
                        loaded_next  = 1'b1;
                    end
                    else
                    begin
                        req.wr_en    = 1'b1;
                        pointer_next = pointer_reg + 8'd1;
                    end
                    done_next = 1'b1;
                    kind_next = i2c_rf_pkg::KIND_ACK;
                end
                i2c_rf_pkg::OP_READ:
                begin
                    // Reads use the pointer whatever the load flag says.
                    req.rd_en    = 1'b1;
                    ident_next   = (pointer_reg == i2c_rf_pkg::IDENTITY_INDEX);
                    pointer_next = pointer_reg + 8'd1;
                    done_next    = 1'b1;
                    kind_next    = i2c_rf_pkg::KIND_READ;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= i2c_rf_pkg::OWN_ADDR_RESET;
            pointer_reg     <= 8'h00;
            loaded_reg      <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                own_address_reg <= cfg_data;
            end
            pointer_reg <= pointer_next;
            loaded_reg  <= loaded_next;
            done_reg    <= done_next;
        end
    end

    // Reply payload; only meaningful while done is high.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        ident_reg <= ident_next;
        if (take)
        begin
            addr_reg <= own_address_reg;
        end
    end

    i2c_rf_store #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    // The identity register answers with its fixed value even after a write there.
    always_comb
    begin
        result.reply_kind    = kind_reg;
        result.reply_address = addr_reg;
        if (kind_reg == i2c_rf_pkg::KIND_ACK)
        begin
            result.reply_byte = i2c_rf_pkg::ACK_BYTE;
        end
        else if (ident_reg)
        begin
            result.reply_byte = i2c_rf_pkg::IDENTITY_VALUE;
        end
        else
        begin
            result.reply_byte = rd_data;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/i2c_rf_checker.sv
// Port-level checker for the register file target, with its bind statement.
// Depends on i2c_rf_pkg and on the ports of i2c_register_file_target.
`default_nettype none

module i2c_rf_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire i2c_rf_pkg::item_t   item,
    input wire logic                done,
    input wire i2c_rf_pkg::result_t result
);

    // A reply only ever follows an item taken in the cycle before.
    a_done_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("reply without an item taken in the previous cycle");

    // The echoed address is the address the item carried.
    a_addr_echo: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.reply_address == $past(item.bus_address[7:1])))
        else $error("reply address differs from the item's address");

    // A stop never produces a reply.
    a_no_stop_reply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(item.opcode) != i2c_rf_pkg::OP_STOP))
        else $error("reply produced for a stop");

    // Read replies answer reads, acknowledges answer the rest, and carry one.
    a_kind_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.reply_kind == i2c_rf_pkg::KIND_READ)
                  == ($past(item.opcode) == i2c_rf_pkg::OP_READ))
                 && (result.reply_kind == i2c_rf_pkg::KIND_READ
                     || result.reply_byte == i2c_rf_pkg::ACK_BYTE))
        else $error("reply kind or acknowledge byte wrong");

endmodule

bind i2c_register_file_target i2c_rf_checker u_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the two-wire register file target: a reply
// scoreboard class predicts each reply and plain tasks drive bus conditions.
// Depends on rtl/i2c_rf_pkg.sv and rtl/i2c_register_file_target.sv.
`timescale 1ns / 100ps

module tb;

    localparam int REG_COUNT = 256;

    // Scoreboard. It keeps its own copy of the register store, the pointer,
    // the load flag and the own address. Every accepted item is run through
    // it, and any reply that the item causes is queued for the checker.
    class reply_scoreboard;
        logic [6:0]          own_addr;
        logic [7:0]          regs [REG_COUNT];
        logic [7:0]          ptr;
        bit                  ptr_loaded;
        i2c_rf_pkg::result_t pending_replies [$];
        int                  errors;
        int                  acks_seen;
        int                  reads_seen;
        int                  identity_reads;
        int                  ignored_items;

        function new();
            own_addr       = i2c_rf_pkg::OWN_ADDR_RESET;
            ptr            = 8'h00;
            ptr_loaded     = 1'b0;
            errors         = 0;
            acks_seen      = 0;
            reads_seen     = 0;
            identity_reads = 0;
            ignored_items  = 0;
            foreach (regs[i])
                regs[i] = 8'h00;
        endfunction

        function void set_address(input logic [6:0] a);
            own_addr = a;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // Works out the reply, if any, that one accepted item causes.
        function void note_item(input i2c_rf_pkg::item_t it);
            i2c_rf_pkg::result_t r;
            logic [7:0]          value;
            r.reply_address = own_addr;
            r.reply_kind    = i2c_rf_pkg::KIND_ACK;
            r.reply_byte    = i2c_rf_pkg::ACK_BYTE;
            // The direction bit is not part of the address comparison.
            if (it.bus_address[7:1] != own_addr || it.opcode == i2c_rf_pkg::OP_STOP)
            begin
                ignored_items++;
                return;
            end
            case (it.opcode)
                i2c_rf_pkg::OP_START:
                begin
                    ptr_loaded = 1'b0;
                end
                i2c_rf_pkg::OP_WRITE:
                begin
                    if (!ptr_loaded)
                    begin
                        ptr        = it.write_byte;
                        ptr_loaded = 1'b1;
                    end
                    else
                    begin
                        regs[ptr % REG_COUNT] = it.write_byte;
                        ptr = ptr + 8'd1;
                    end
                end
                default:
                begin
                    // The identity register masks whatever the store holds.
                    if (ptr == i2c_rf_pkg::IDENTITY_INDEX)
                    begin
                        value = i2c_rf_pkg::IDENTITY_VALUE;
                        identity_reads++;
                    end
                    else
                    begin
                        value = regs[ptr % REG_COUNT];
                    end
                    ptr          = ptr + 8'd1;
                    r.reply_kind = i2c_rf_pkg::KIND_READ;
                    r.reply_byte = value;
                end
            endcase
            pending_replies.push_back(r);
        endfunction

        // Compares one reply from the block with the oldest prediction.
        function void check_reply(input i2c_rf_pkg::result_t got);
            i2c_rf_pkg::result_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with none expected: kind %0d byte %h address %h",
                         $time, got.reply_kind, got.reply_byte, got.reply_address);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (want.reply_kind == i2c_rf_pkg::KIND_READ)
                reads_seen++;
            else
                acks_seen++;
            if (got.reply_kind !== want.reply_kind)
            begin
                $display("%0t: reply_kind expected %0d, got %0d",
                         $time, want.reply_kind, got.reply_kind);
                errors++;
            end
            if (got.reply_byte !== want.reply_byte)
            begin
                $display("%0t: reply_byte expected %h, got %h",
                         $time, want.reply_byte, got.reply_byte);
                errors++;
            end
            if (got.reply_address !== want.reply_address)
            begin
                $display("%0t: reply_address expected %h, got %h",
                         $time, want.reply_address, got.reply_address);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    i2c_rf_pkg::item_t   item_in = '0;
    logic                done;
    i2c_rf_pkg::result_t result;
    logic                cfg_we = 1'b0;
    logic [6:0]          cfg_data = 7'h00;

    reply_scoreboard sb;

    // Items that reach the register logic, i.e. addressed to us and not a stop.
    int  live_items = 0;
    int  settings_used = 0;
    // No idle gaps at all while quiet is set; calm suppresses them for one
    // transaction so that back-to-back stretches also occur.
    bit  quiet = 1'b0;
    bit  calm = 1'b0;

    i2c_register_file_target #(
        .REGISTER_COUNT(REG_COUNT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item_in),
        .done    (done),
        .result  (result),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One process both checks replies and notes accepted items, so the order
    // of the two is fixed: a reply is always checked before an item
    // accepted at the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_reply(result);
            if (start && !busy)
                sb.note_item(item_in);
        end
    end

    // Offers one item from a falling edge and holds it until it is accepted.
    // An idle burst of random length may come first.
    task automatic drive_item(input i2c_rf_pkg::item_t it);
        if (!quiet && !calm && $urandom_range(0, 4) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        start   = 1'b1;
        item_in = it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (it.bus_address[7:1] == sb.own_addr && it.opcode != i2c_rf_pkg::OP_STOP)
            live_items++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic issue(input i2c_rf_pkg::opcode_t op, input logic [7:0] addr,
                         input logic [7:0] data);
        i2c_rf_pkg::item_t it;
        it.opcode      = op;
        it.bus_address = addr;
        it.write_byte  = data;
        drive_item(it);
    endtask

    // The own address may only change while the block is idle. A stop or a
    // foreign item gives no reply, so a short pause covers any such item that
    // may still be in flight.
    task automatic write_address(input logic [6:0] a);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = a;
        @(negedge clk);
        cfg_we   = 1'b0;
        sb.set_address(a);
        settings_used++;
    endtask

    // Register pointers are drawn mostly from small windows, so that reads
    // often find data written earlier, and windows around the identity
    // register and the wrap from 0xFF to 0x00 are visited often.
    function automatic logic [7:0] pick_pointer();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'h72 + 8'($urandom_range(0, 5));
            2:       return 8'hF9 + 8'($urandom_range(0, 6));
            default: return 8'($urandom_range(0, 15));
        endcase
    endfunction

    // One random bus transaction. Most are well formed: a start, a pointer
    // load, then data writes, or a repeated start and reads. The rest are
    // noise with any address, or broken sequences without a proper start.
    task automatic random_transaction();
        int         pick;
        int         n;
        logic [6:0] a;
        logic [7:0] p;
        a    = sb.own_addr;
        pick = $urandom_range(0, 99);
        p    = pick_pointer();
        n    = $urandom_range(1, 8);
        calm = ($urandom_range(0, 3) == 0);
        if (pick < 40)
        begin
            issue(i2c_rf_pkg::OP_START, {a, 1'b0}, 8'($urandom));
            issue(i2c_rf_pkg::OP_WRITE, {a, 1'b0}, p);
            for (int i = 0; i < n; i++)
                issue(i2c_rf_pkg::OP_WRITE, {a, 1'b0}, 8'($urandom));
            if ($urandom_range(0, 3) != 0)
                issue(i2c_rf_pkg::OP_STOP, {a, 1'($urandom)}, 8'($urandom));
        end
        else if (pick < 80)
        begin
            issue(i2c_rf_pkg::OP_START, {a, 1'b0}, 8'($urandom));
            issue(i2c_rf_pkg::OP_WRITE, {a, 1'b0}, p);
            issue(i2c_rf_pkg::OP_START, {a, 1'b1}, 8'($urandom));
            for (int i = 0; i < n; i++)
                issue(i2c_rf_pkg::OP_READ, {a, 1'b1}, 8'($urandom));
            if ($urandom_range(0, 3) != 0)
                issue(i2c_rf_pkg::OP_STOP, {a, 1'b1}, 8'($urandom));
        end
        else if (pick < 90)
        begin
            for (int i = 0; i < n; i++)
                issue(i2c_rf_pkg::opcode_t'($urandom_range(0, 3)), 8'($urandom),
                      8'($urandom));
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    issue(i2c_rf_pkg::opcode_t'($urandom_range(1, 3)), 8'($urandom),
                          8'($urandom));
                else
                    issue(i2c_rf_pkg::opcode_t'($urandom_range(1, 3)), {a, 1'($urandom)},
                          8'($urandom));
            end
        end
        calm = 1'b0;
    endtask

    // A generous bound on the whole run; the slowest correct run is well
    // under a tenth of it.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [7:0] wa;
        logic [7:0] ra;
        logic [7:0] other;
        logic [6:0] a;
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset address.
        wa    = {i2c_rf_pkg::OWN_ADDR_RESET, 1'b0};
        ra    = {i2c_rf_pkg::OWN_ADDR_RESET, 1'b1};
        other = {i2c_rf_pkg::OWN_ADDR_RESET ^ 7'h01, 1'b0};
        // A read before any pointer load uses the reset pointer.
        issue(i2c_rf_pkg::OP_READ, wa, 8'h00);
        // Load the pointer near the top and write across the wrap.
        issue(i2c_rf_pkg::OP_START, wa, 8'hFF);
        issue(i2c_rf_pkg::OP_WRITE, wa, 8'hFE);
        issue(i2c_rf_pkg::OP_WRITE, wa, 8'hFF);
        issue(i2c_rf_pkg::OP_WRITE, wa, 8'h00);
        issue(i2c_rf_pkg::OP_WRITE, wa, 8'h11);
        // Read the same bytes back across the wrap.
        issue(i2c_rf_pkg::OP_START, wa, 8'h00);
        issue(i2c_rf_pkg::OP_WRITE, wa, 8'hFE);
        issue(i2c_rf_pkg::OP_START, ra, 8'h00);
        issue(i2c_rf_pkg::OP_READ, ra, 8'h00);
        issue(i2c_rf_pkg::OP_READ, ra, 8'h00);
        issue(i2c_rf_pkg::OP_READ, ra, 8'h00);
        // A write to the identity register lands in the store, yet a read
        // there still returns the fixed identity.
        issue(i2c_rf_pkg::OP_START, wa, 8'h00);
        issue(i2c_rf_pkg::OP_WRITE, wa, i2c_rf_pkg::IDENTITY_INDEX);
        issue(i2c_rf_pkg::OP_WRITE, wa, 8'h5A);
        issue(i2c_rf_pkg::OP_START, wa, 8'h00);
        issue(i2c_rf_pkg::OP_WRITE, wa, 8'h74);
        issue(i2c_rf_pkg::OP_READ, ra, 8'h00);
        issue(i2c_rf_pkg::OP_READ, ra, 8'h00);
        issue(i2c_rf_pkg::OP_READ, ra, 8'h00);
        // A stop, and items for another target, change nothing.
        issue(i2c_rf_pkg::OP_STOP, wa, 8'hFF);
        issue(i2c_rf_pkg::OP_WRITE, other, 8'hA5);
        issue(i2c_rf_pkg::OP_READ, other, 8'h00);
        issue(i2c_rf_pkg::OP_START, other, 8'h00);
        issue(i2c_rf_pkg::OP_STOP, other, 8'h00);

        // Random part: several address settings, the extremes first, with
        // the last phases run without any idle gaps.
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0:       a = 7'h00;
                1:       a = 7'h7F;
                5:       a = i2c_rf_pkg::OWN_ADDR_RESET;
                default: a = 7'($urandom_range(0, 127));
            endcase
            write_address(a);
            quiet = (phase >= 10);
            begin
                int target;
                target = live_items + 105;
                while (live_items < target)
                    random_transaction();
            end
        end

        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Run covered %0d items for this target over %0d address settings.",
                 live_items, settings_used);
        $display("Replies: %0d acknowledges, %0d reads (%0d of the identity), %0d ignored.",
                 sb.acks_seen, sb.reads_seen, sb.identity_reads, sb.ignored_items);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
